[src/txcon_pkg.sv]
// Shared constants for the text console writer: screen geometry defaults,
// command codes, control characters and field widths. No dependencies.
package txcon_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	localparam int CELL_BITS = 16;
	localparam int CHAR_BITS = 8;
	localparam int IDX_BITS  = 11;
	localparam int OCOL_BITS = 7;
	localparam int OROW_BITS = 5;
	localparam int OOFF_BITS = 11;

	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_BITS-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_BITS-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'd32;

	localparam logic [CHAR_BITS-1:0] TEXT_COLOR_RST = 8'd7;

endpackage

[src/text_console_writer.sv]
// Text console writer: screen cell memory, cursor and a sequencer that runs
// put, read and clear commands. Depends on txcon_pkg.
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    cmd, char_code, cell_index
// out      output     out_valid / out_ready  cell_value, cursor_col/row/offset
// cfg      input      text_color_we          text_color
//
// A read passes through the read and done states; return, line feed off the last
// row and unused commands go straight to done; a printable character is stored,
// then done; a tab stores one space per step up to the next tab stop; a wrap adds
// a store step. A line feed on the last row scrolls through the single memory port
// pair, moving each row up by one; clear sweeps the whole memory. After reset a
// clearing pass runs with in_ready low. A stalled result holds in the output
// register while the next transaction is accepted.
module text_console_writer import txcon_pkg::*; #(
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int ROWS     = ROWS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_color_we,
	input  logic [CHAR_BITS-1:0] text_color,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [CHAR_BITS-1:0] char_code,
	input  logic [IDX_BITS-1:0]  cell_index,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CELL_BITS-1:0] cell_value,
	output logic [OCOL_BITS-1:0] cursor_col,
	output logic [OROW_BITS-1:0] cursor_row,
	output logic [OOFF_BITS-1:0] cursor_offset
);

	localparam int CELLS    = ROWS * COLUMNS;
	localparam int SCROLL_N = COLUMNS * (ROWS - 1);
	localparam int COL_W    = $clog2(COLUMNS + 1);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int CNT_W    = $clog2(CELLS + 1);
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int MOD_W    = $clog2(TAB_STOP);
	localparam int TABN_W   = $clog2(TAB_STOP + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLEAR  = 3'd1;
	localparam logic [2:0] S_STORE  = 3'd2;
	localparam logic [2:0] S_SCROLL = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [CELL_BITS-1:0] mem_q [CELLS];
	logic [CELL_BITS-1:0] rd_q;

	logic [2:0]           state_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [CNT_W-1:0]     base_q;
	logic [MOD_W-1:0]     mod_q;
	logic [TABN_W-1:0]    tabn_q;
	logic                 tab_q;
	logic                 clr_done_q;
	logic                 sc_ret_q;
	logic                 rd_ok_q;
	logic [CHAR_BITS-1:0] ch_q;
	logic [CHAR_BITS-1:0] color_q;
	logic [CELL_BITS-1:0] cell_q;
	logic                 out_valid_q;
	logic [CELL_BITS-1:0] out_cell_q;
	logic [OCOL_BITS-1:0] out_col_q;
	logic [OROW_BITS-1:0] out_row_q;
	logic [OOFF_BITS-1:0] out_off_q;

	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [CELL_BITS-1:0] wr_data;
	logic [ADDR_W-1:0]    rd_addr;
	logic [CNT_W-1:0]     cur_off;
	logic                 idx_ok;
	logic                 wrap;
	logic                 row_last;
	logic [MOD_W-1:0]     mod_nx;
	logic [TABN_W-1:0]    tabn_nx;

	assign cur_off  = base_q + CNT_W'(col_q);
	assign idx_ok   = 32'(cell_index) < CELLS;
	assign wrap     = col_q >= COL_W'(COLUMNS);
	assign row_last = row_q == ROW_W'(ROWS - 1);
	assign mod_nx   = (mod_q == MOD_W'(TAB_STOP - 1)) ? '0 : mod_q + 1'b1;
	assign tabn_nx  = tabn_q + 1'b1;

	assign in_ready      = state_q == S_IDLE;
	assign out_valid     = out_valid_q;
	assign cell_value    = out_cell_q;
	assign cursor_col    = out_col_q;
	assign cursor_row    = out_row_q;
	assign cursor_offset = out_off_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (idx_ok)
					rd_addr = ADDR_W'(cell_index);
			end
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[ADDR_W-1:0];
			end
			S_STORE: begin
				wr_en   = !wrap;
				wr_addr = cur_off[ADDR_W-1:0];
				wr_data = {color_q, ch_q};
			end
			S_SCROLL: begin
				if (ptr_q < CNT_W'(SCROLL_N))
					rd_addr = ADDR_W'(ptr_q + CNT_W'(COLUMNS));
				if (ptr_q != '0) begin
					wr_en   = 1'b1;
					wr_addr = ADDR_W'(ptr_q - 1'b1);
					wr_data = rd_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			col_q       <= COL_W'(1);
			row_q       <= ROW_W'(1);
			base_q      <= CNT_W'(COLUMNS);
			mod_q       <= MOD_W'(1);
			tabn_q      <= '0;
			tab_q       <= 1'b0;
			clr_done_q  <= 1'b0;
			sc_ret_q    <= 1'b0;
			rd_ok_q     <= 1'b0;
			ch_q        <= '0;
			color_q     <= TEXT_COLOR_RST;
			cell_q      <= '0;
			out_valid_q <= 1'b0;
			out_cell_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_off_q   <= '0;
		end else begin
			if (text_color_we)
				color_q <= text_color;
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cell_q  <= '0;
						ch_q    <= char_code;
						tab_q   <= 1'b0;
						tabn_q  <= '0;
						rd_ok_q <= idx_ok;
						unique case (cmd)
							CMD_PUT: begin
								case (char_code)
									CH_LF: begin
										col_q <= '0;
										mod_q <= '0;
										if (row_last) begin
											ptr_q    <= '0;
											sc_ret_q <= 1'b0;
											state_q  <= S_SCROLL;
										end else begin
											row_q   <= row_q + 1'b1;
											base_q  <= base_q + CNT_W'(COLUMNS);
											state_q <= S_DONE;
										end
									end
									CH_CR: begin
										col_q   <= '0;
										mod_q   <= '0;
										state_q <= S_DONE;
									end
									CH_TAB: begin
										ch_q    <= CH_SPACE;
										tab_q   <= 1'b1;
										state_q <= S_STORE;
									end
									default: state_q <= S_STORE;
								endcase
							end
							CMD_READ: state_q <= S_READ;
							CMD_CLEAR: begin
								ptr_q      <= '0;
								clr_done_q <= 1'b1;
								col_q      <= COL_W'(1);
								row_q      <= ROW_W'(1);
								base_q     <= CNT_W'(COLUMNS);
								mod_q      <= MOD_W'(1);
								state_q    <= S_CLEAR;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == CNT_W'(CELLS - 1))
						state_q <= clr_done_q ? S_DONE : S_IDLE;
				end
				S_STORE: begin
					if (wrap) begin
						col_q <= '0;
						mod_q <= '0;
						if (row_last) begin
							ptr_q    <= '0;
							sc_ret_q <= 1'b1;
							state_q  <= S_SCROLL;
						end else begin
							row_q  <= row_q + 1'b1;
							base_q <= base_q + CNT_W'(COLUMNS);
						end
					end else begin
						col_q  <= col_q + 1'b1;
						mod_q  <= mod_nx;
						tabn_q <= tabn_nx;
						if (!(tab_q && mod_nx != '0 && tabn_nx < TABN_W'(TAB_STOP)))
							state_q <= S_DONE;
					end
				end
				S_SCROLL: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_q == CNT_W'(SCROLL_N))
						state_q <= sc_ret_q ? S_STORE : S_DONE;
				end
				S_READ: begin
					if (rd_ok_q)
						cell_q <= rd_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_cell_q  <= cell_q;
						out_col_q   <= OCOL_BITS'(col_q);
						out_row_q   <= OROW_BITS'(row_q);
						out_off_q   <= OOFF_BITS'(cur_off);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(COLUMNS))
		else $error("cursor column beyond screen width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < ROWS)
		else $error("cursor row beyond screen height");

	a_base_track: assert property (@(posedge clk) disable iff (!arst_n)
		base_q == CNT_W'(32'(row_q) * COLUMNS))
		else $error("row base out of step with cursor row");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !wr_en)
		else $error("cell memory written while idle");

	a_scroll_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCROLL |-> ptr_q <= CNT_W'(SCROLL_N))
		else $error("scroll pointer overran the copy range");

endmodule
